// File: design/xsr_pkg.sv
// xsr_pkg: shared types and constants for the bounded xoshiro256** generator
// used by xsr_ctrl, xsr_dp, xoshiro256_bounded_rng and xsr_chk; no dependencies
package xsr_pkg;

  localparam int WORD_W = 64;
  localparam int NIB_W  = 4;
  localparam int MUL_STEPS = WORD_W / NIB_W;
  localparam int CNT_W  = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  localparam int MIX_SH_A = 30;
  localparam int MIX_SH_B = 27;
  localparam int MIX_SH_C = 31;
  localparam int ROT_W3   = 45;
  localparam int SHL_T    = 17;
  localparam int ROT_RES  = 7;

  localparam logic [1:0] OP_RAW     = 2'd0;
  localparam logic [1:0] OP_BOUNDED = 2'd1;
  localparam logic [1:0] OP_RESEED  = 2'd2;

  typedef enum logic [4:0] {
    S_BOOT,
    S_IDLE,
    S_DECODE,
    S_SEED,
    S_MIX_A,
    S_MUL_A,
    S_MIX_B,
    S_MUL_B,
    S_MIX_STORE,
    S_DIV1_START,
    S_DIV1,
    S_BUCKETS,
    S_MUL_LIM,
    S_LIMIT,
    S_DRAW,
    S_MUL9,
    S_CHECK,
    S_DIV2_START,
    S_DIV2,
    S_FINISH
  } xsr_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_SEED_ZERO,
    CMD_SEED,
    CMD_MIX_A,
    CMD_MIX_B,
    CMD_MIX_STORE,
    CMD_MUL_STEP,
    CMD_DIV1,
    CMD_DIV_STEP,
    CMD_BUCKETS,
    CMD_LIMIT,
    CMD_DRAW,
    CMD_MUL9,
    CMD_DIV2
  } xsr_dp_op_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_ERR,
    OUT_DRAW,
    OUT_QUOT
  } xsr_out_sel_t;

  typedef struct packed {
    xsr_dp_op_t   op;
    xsr_out_sel_t out_sel;
    logic         out_load;
    logic         capture;
  } xsr_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bound_zero;
    logic       mul_last;
    logic       div_last;
    logic       mix_last;
    logic       reject;
  } xsr_stat_t;

endpackage

// File: design/xsr_ctrl.sv
// xsr_ctrl: sequencing state machine for the bounded xoshiro256** generator
// depends on xsr_pkg; drives xsr_dp through xsr_cmd_t and reads xsr_stat_t
module xsr_ctrl
  import xsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  xsr_stat_t stat,
  output xsr_cmd_t  cmd
);

  xsr_state_t   state, state_next;
  logic         boot, boot_next;
  xsr_out_sel_t fin_sel, fin_sel_next;
  logic         out_valid_next;
  logic         slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT;
      boot      <= 1'b1;
      fin_sel   <= OUT_ZERO;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      boot      <= boot_next;
      fin_sel   <= fin_sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    boot_next    = boot;
    fin_sel_next = fin_sel;
    case (state)
      S_BOOT:       state_next = S_MIX_A;
      S_IDLE:       if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (stat.op)
          OP_RAW: begin
            state_next   = S_DRAW;
            fin_sel_next = OUT_DRAW;
          end
          OP_BOUNDED: begin
            if (stat.bound_zero) begin
              state_next   = S_FINISH;
              fin_sel_next = OUT_ERR;
            end else begin
              state_next = S_DIV1_START;
            end
          end
          OP_RESEED:    state_next = S_SEED;
          default: begin
            state_next   = S_FINISH;
            fin_sel_next = OUT_ZERO;
          end
        endcase
      end
      S_SEED:       state_next = S_MIX_A;
      S_MIX_A:      state_next = S_MUL_A;
      S_MUL_A:      if (stat.mul_last) state_next = S_MIX_B;
      S_MIX_B:      state_next = S_MUL_B;
      S_MUL_B:      if (stat.mul_last) state_next = S_MIX_STORE;
      S_MIX_STORE: begin
        if (!stat.mix_last) begin
          state_next = S_MIX_A;
        end else if (boot) begin
          state_next = S_IDLE;
          boot_next  = 1'b0;
        end else begin
          state_next   = S_FINISH;
          fin_sel_next = OUT_ZERO;
        end
      end
      S_DIV1_START: state_next = S_DIV1;
      S_DIV1:       if (stat.div_last) state_next = S_BUCKETS;
      S_BUCKETS:    state_next = S_MUL_LIM;
      S_MUL_LIM:    if (stat.mul_last) state_next = S_LIMIT;
      S_LIMIT:      state_next = S_DRAW;
      S_DRAW:       state_next = S_MUL9;
      S_MUL9: begin
        if (stat.op == OP_RAW) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.reject) begin
          state_next = S_DRAW;
        end else begin
          state_next = S_DIV2_START;
        end
      end
      S_DIV2_START: state_next = S_DIV2;
      S_DIV2: begin
        if (stat.div_last) begin
          state_next   = S_FINISH;
          fin_sel_next = OUT_QUOT;
        end
      end
      S_FINISH:     if (slot_free) state_next = S_IDLE;
      default:      state_next = S_BOOT;
    endcase
  end

  always_comb begin
    cmd.op       = CMD_NONE;
    cmd.out_sel  = fin_sel;
    cmd.out_load = 1'b0;
    cmd.capture  = 1'b0;
    in_stall     = 1'b1;
    case (state)
      S_BOOT:       cmd.op = CMD_SEED_ZERO;
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_SEED:       cmd.op = CMD_SEED;
      S_MIX_A:      cmd.op = CMD_MIX_A;
      S_MUL_A:      cmd.op = CMD_MUL_STEP;
      S_MIX_B:      cmd.op = CMD_MIX_B;
      S_MUL_B:      cmd.op = CMD_MUL_STEP;
      S_MIX_STORE:  cmd.op = CMD_MIX_STORE;
      S_DIV1_START: cmd.op = CMD_DIV1;
      S_DIV1:       cmd.op = CMD_DIV_STEP;
      S_BUCKETS:    cmd.op = CMD_BUCKETS;
      S_MUL_LIM:    cmd.op = CMD_MUL_STEP;
      S_LIMIT:      cmd.op = CMD_LIMIT;
      S_DRAW:       cmd.op = CMD_DRAW;
      S_MUL9:       cmd.op = CMD_MUL9;
      S_DIV2_START: cmd.op = CMD_DIV2;
      S_DIV2:       cmd.op = CMD_DIV_STEP;
      S_FINISH:     cmd.out_load = slot_free;
      default:      cmd.op = CMD_NONE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

endmodule

// File: design/xsr_dp.sv
// xsr_dp: generator state words, shared 4-bit-per-step multiplier,
// 1-bit-per-step restoring divider and result register; depends on xsr_pkg
module xsr_dp
  import xsr_pkg::*;
(
  input  logic              clk,
  input  logic [1:0]        op,
  input  logic [WORD_W-1:0] operand,
  input  xsr_cmd_t          cmd,
  output xsr_stat_t         stat,
  output logic [WORD_W-1:0] value,
  output logic              error
);

  logic [WORD_W-1:0] words [4];
  logic [1:0]        op_q;
  logic [WORD_W-1:0] opnd;
  logic [WORD_W-1:0] ctr;
  logic [1:0]        idx;
  logic [WORD_W-1:0] mul_a, mul_b, acc;
  logic [WORD_W-1:0] rem, quo, dvs;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] buckets, limit, r;

  logic [WORD_W-1:0]       ctr_inc;
  logic [WORD_W+NIB_W-1:0] pp;
  logic [WORD_W:0]         trial, diff;
  logic                    fits;
  logic [WORD_W-1:0]       w5, res_rot, t_sh;
  logic [WORD_W-1:0]       a2, a3, n0, n1, n2, n3;

  assign ctr_inc = ctr + GOLDEN_STEP;
  assign pp      = mul_a * mul_b[NIB_W-1:0];
  assign trial   = {rem, quo[WORD_W-1]};
  assign diff    = trial - {1'b0, dvs};
  assign fits    = !diff[WORD_W];

  // xoshiro256** output and state update
  assign w5      = words[1] + (words[1] << 2);
  assign res_rot = (w5 << ROT_RES) | (w5 >> (WORD_W - ROT_RES));
  assign t_sh    = words[1] << SHL_T;
  assign a2      = words[2] ^ words[0];
  assign a3      = words[3] ^ words[1];
  assign n1      = words[1] ^ a2;
  assign n0      = words[0] ^ a3;
  assign n2      = a2 ^ t_sh;
  assign n3      = (a3 << ROT_W3) | (a3 >> (WORD_W - ROT_W3));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op;
      opnd <= operand;
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_ERR: begin
          value <= '0;
          error <= 1'b1;
        end
        OUT_DRAW: begin
          value <= r;
          error <= 1'b0;
        end
        OUT_QUOT: begin
          value <= quo;
          error <= 1'b0;
        end
        default: begin
          value <= '0;
          error <= 1'b0;
        end
      endcase
    end
    case (cmd.op)
      CMD_SEED_ZERO: begin
        words[0] <= '0;
        ctr      <= '0;
        idx      <= 2'd1;
      end
      CMD_SEED: begin
        words[0] <= opnd;
        ctr      <= opnd;
        idx      <= 2'd1;
      end
      CMD_MIX_A: begin
        ctr   <= ctr_inc;
        mul_a <= ctr_inc ^ (ctr_inc >> MIX_SH_A);
        mul_b <= MIX_MUL_A;
        acc   <= '0;
        cnt   <= '0;
      end
      CMD_MIX_B: begin
        mul_a <= acc ^ (acc >> MIX_SH_B);
        mul_b <= MIX_MUL_B;
        acc   <= '0;
        cnt   <= '0;
      end
      CMD_MIX_STORE: begin
        words[idx] <= acc ^ (acc >> MIX_SH_C);
        idx        <= idx + 2'd1;
      end
      CMD_MUL_STEP: begin
        acc   <= acc + pp[WORD_W-1:0];
        mul_a <= mul_a << NIB_W;
        mul_b <= mul_b >> NIB_W;
        cnt   <= cnt + 1'b1;
      end
      CMD_DIV1: begin
        quo <= '1;
        rem <= '0;
        dvs <= opnd;
        cnt <= '0;
      end
      CMD_DIV_STEP: begin
        rem <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], fits};
        cnt <= cnt + 1'b1;
      end
      CMD_BUCKETS: begin
        buckets <= quo;
        mul_a   <= quo;
        mul_b   <= opnd;
        acc     <= '0;
        cnt     <= '0;
      end
      CMD_LIMIT:     limit <= acc;
      CMD_DRAW: begin
        words[0] <= n0;
        words[1] <= n1;
        words[2] <= n2;
        words[3] <= n3;
        r        <= res_rot;
      end
      CMD_MUL9:      r <= r + (r << 3);
      CMD_DIV2: begin
        quo <= r;
        rem <= '0;
        dvs <= buckets;
        cnt <= '0;
      end
      default: ;
    endcase
  end

  assign stat.op         = op_q;
  assign stat.bound_zero = (opnd == '0);
  assign stat.mul_last   = (cnt == CNT_W'(MUL_STEPS - 1));
  assign stat.div_last   = (cnt == CNT_W'(WORD_W - 1));
  assign stat.mix_last   = (idx == 2'd3);
  assign stat.reject     = (r >= limit);

endmodule

// File: design/xoshiro256_bounded_rng.sv
// xoshiro256_bounded_rng: top level of the bounded xoshiro256** generator
// depends on xsr_pkg, xsr_ctrl and xsr_dp
//
//   channel | handshake           | word
//   in      | in_valid, in_stall  | op, operand
//   out     | out_valid, out_stall| value, error
//
// one word at a time; a bounded draw repeats the draw for each rejected value,
// and a zero bound or unused op goes straight from decode to the result
// the 64-step restoring divider (run twice) and 16-step multiplier set the pace
// after reset a seed-zero pass runs with in_stall high
// a finished word waits in the output register while the next word is worked on
module xoshiro256_bounded_rng
  import xsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [WORD_W-1:0] operand,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] value,
  output logic              error
);

  xsr_cmd_t  cmd;
  xsr_stat_t stat;

  xsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  xsr_dp u_dp (
    .clk     (clk),
    .op      (op),
    .operand (operand),
    .cmd     (cmd),
    .stat    (stat),
    .value   (value),
    .error   (error)
  );

endmodule

// File: design/xsr_chk.sv
// xsr_chk: port-level checks for xoshiro256_bounded_rng, bound to the top level
// depends on xsr_pkg
module xsr_chk
  import xsr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        op,
  input logic [WORD_W-1:0] operand,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] value,
  input logic              error
);

  // seed-zero pass holds off input right after reset
  a_boot_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during seed pass");

  // one word in flight
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> value == '0)
    else $error("error word with nonzero value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(error))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(op) && $stable(operand))
    else $error("stalled input word changed");

endmodule

bind xoshiro256_bounded_rng xsr_chk u_chk (.*);

// File: verif/testbench.sv
// testbench for the bounded xoshiro256** generator: directed and random words,
// checked against a behavioral copy of the generator kept in a scoreboard class
// depends on xsr_pkg and xoshiro256_bounded_rng
class rng_scoreboard;
  logic [63:0] words [4];
  logic [63:0] mix_ctr;
  logic [63:0] want_value [$];
  logic        want_error [$];
  int failures, checked;
  int raw_words, bounded_words, redraws, reseeds, zero_bounds, ignored_words;

  function new();
    load_seed(64'd0);
  endfunction

  function logic [63:0] rotl(logic [63:0] v, int unsigned k);
    return (v << k) | (v >> (xsr_pkg::WORD_W - k));
  endfunction

  function logic [63:0] splitmix_next();
    logic [63:0] z;
    mix_ctr = mix_ctr + xsr_pkg::GOLDEN_STEP;
    z = mix_ctr;
    z = (z ^ (z >> xsr_pkg::MIX_SH_A)) * xsr_pkg::MIX_MUL_A;
    z = (z ^ (z >> xsr_pkg::MIX_SH_B)) * xsr_pkg::MIX_MUL_B;
    return z ^ (z >> xsr_pkg::MIX_SH_C);
  endfunction

  function void load_seed(logic [63:0] seed);
    mix_ctr = seed;
    words[0] = seed;
    words[1] = splitmix_next();
    words[2] = splitmix_next();
    words[3] = splitmix_next();
  endfunction

  function logic [63:0] next_draw();
    logic [63:0] res;
    logic [63:0] t;
    res = rotl(words[1] * 64'd5, xsr_pkg::ROT_RES) * 64'd9;
    t = words[1] << xsr_pkg::SHL_T;
    words[2] ^= words[0];
    words[3] ^= words[1];
    words[1] ^= words[2];
    words[0] ^= words[3];
    words[2] ^= t;
    words[3] = rotl(words[3], xsr_pkg::ROT_W3);
    return res;
  endfunction

  // accepted input word: work out the result it must produce
  function void note_word(logic [1:0] o, logic [63:0] arg);
    logic [63:0] val;
    logic        err;
    logic [63:0] buckets;
    logic [63:0] limit;
    logic [63:0] r;
    val = 64'd0;
    err = 1'b0;
    case (o)
      xsr_pkg::OP_RAW: begin
        val = next_draw();
        raw_words++;
      end
      xsr_pkg::OP_BOUNDED: begin
        bounded_words++;
        if (arg == 64'd0) begin
          err = 1'b1;
          zero_bounds++;
        end else begin
          buckets = ~64'd0 / arg;
          limit = buckets * arg;
          r = next_draw();
          while (r >= limit) begin
            r = next_draw();
            redraws++;
          end
          val = r / buckets;
        end
      end
      xsr_pkg::OP_RESEED: begin
        load_seed(arg);
        reseeds++;
      end
      default: ignored_words++;
    endcase
    want_value.push_back(val);
    want_error.push_back(err);
  endfunction

  function void check_word(logic [63:0] v, logic e);
    logic [63:0] wv;
    logic        we;
    if (want_value.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected result word: value %h error %b", v, e);
      return;
    end
    wv = want_value.pop_front();
    we = want_error.pop_front();
    checked++;
    if (v !== wv || e !== we) begin
      failures++;
      if (failures <= 10)
        $display("result %0d: expected value %h error %b, got value %h error %b",
                 checked, wv, we, v, e);
    end
  endfunction

  function int pending();
    return want_value.size();
  endfunction
endclass

module testbench;
  import xsr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 980;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 1_000_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        op = OP_RAW;
  logic [WORD_W-1:0] operand = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] value;
  logic              error;

  int idle_in = 16;
  int stall_out = 79;
  rng_scoreboard sb = new();

  xoshiro256_bounded_rng u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .operand   (operand),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .error     (error)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_out);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(value, error);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input logic [1:0] o, input logic [63:0] arg);
    @(negedge clk);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    operand <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(o, arg);
  endtask

  initial begin
    int n;
    int pick;
    logic [1:0] o;
    logic [63:0] arg;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes and special cases
    send_word(OP_RAW, 64'd0);
    send_word(OP_RAW, ~64'd0);
    send_word(OP_BOUNDED, 64'd0);
    send_word(OP_RAW, 64'd0);
    send_word(OP_BOUNDED, 64'd1);
    send_word(OP_BOUNDED, ~64'd0);
    send_word(OP_BOUNDED, 64'h8000_0000_0000_0000);
    send_word(OP_BOUNDED, 64'h8000_0000_0000_0001);
    send_word(OP_BOUNDED, 64'd2);
    send_word(OP_BOUNDED, 64'd3);
    send_word(OP_BOUNDED, 64'd1000);
    send_word(OP_UNUSED, 64'd0);
    send_word(OP_UNUSED, ~64'd0);
    send_word(OP_RAW, 64'd0);
    send_word(OP_RESEED, 64'd0);
    send_word(OP_RAW, 64'd0);
    send_word(OP_RESEED, ~64'd0);
    send_word(OP_RAW, ~64'd0);
    send_word(OP_BOUNDED, 64'd1);
    send_word(OP_RESEED, rand64());
    send_word(OP_BOUNDED, rand64() | 64'd1);
    send_word(OP_RAW, rand64());

    n = 0;
    while (n < RANDOM_WORDS) begin
      if (n == RANDOM_WORDS / 3) begin
        idle_in = 79;
        stall_out = 16;
      end else if (n == 2 * RANDOM_WORDS / 3) begin
        idle_in = 0;
        stall_out = 0;
      end
      arg = rand64();
      pick = $urandom_range(99);
      o = (pick < 30) ? OP_RAW : (pick < 75) ? OP_BOUNDED :
          (pick < 90) ? OP_RESEED : OP_UNUSED;
      if (o == OP_BOUNDED) begin
        case ($urandom_range(5))
          0: arg = 64'($urandom_range(16, 1));
          1: arg = 64'($urandom_range(32'hffff_ffff, 1));
          2: arg = arg;
          3: arg = {1'b1, arg[62:0]};
          4: case ($urandom_range(3))
               0: arg = 64'd0;
               1: arg = 64'd1;
               2: arg = ~64'd0;
               default: arg = 64'h8000_0000_0000_0000;
             endcase
          default: arg = arg >> $urandom_range(63);
        endcase
      end
      send_word(o, arg);
      n++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d raw, %0d bounded (%0d redraws, %0d zero bounds),",
             sb.raw_words, sb.bounded_words, sb.redraws, sb.zero_bounds);
    $display("%0d reseeds, %0d unused; checked %0d result words, %0d failures",
             sb.reseeds, sb.ignored_words, sb.checked, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout with %0d result words outstanding", sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: xoshiro256_bounded_rng.f
design/xsr_pkg.sv
design/xsr_ctrl.sv
design/xsr_dp.sv
design/xoshiro256_bounded_rng.sv
design/xsr_chk.sv
verif/testbench.sv
